@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL of the queue, included by its top level.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked while out of reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/emkq_pkg.sv @@
// Package of the eligible minimum-key queue: entry type, codes and fixed widths.
// Used by every module of the queue; depends on nothing.
package emkq_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int ID_W      = 16;
	localparam int KEY_W     = 32;
	localparam int OCC_W     = 7;
	localparam int STATUS_W  = 3;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic             elig;
		logic [KEY_W-1:0] key;
	} entry_t;

	typedef enum logic {
		CMD_ENQ = 1'b0,
		CMD_DEQ = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_ENQUEUED      = 3'd0,
		ST_FULL          = 3'd1,
		ST_DEQUEUED      = 3'd2,
		ST_EMPTY         = 3'd3,
		ST_NONE_ELIGIBLE = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SCAN_LAST,
		S_DECIDE,
		S_SHIFT,
		S_REMOVE
	} state_t;

endpackage

@@ hw/rtl/emkq_store.sv @@
// Entry memory of the queue: one write port and one read port with registered read data.
// Depends on emkq_pkg for the entry type.
module emkq_store #(
	parameter int DEPTH = emkq_pkg::DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  emkq_pkg::entry_t    wdata,
	input  logic                re,
	input  logic [AW-1:0]       raddr,
	output emkq_pkg::entry_t    rdata
);
	import emkq_pkg::*;

	entry_t mem_q [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/emkq_scan.sv @@
// Shared key comparator that tracks the eligible entry with the smallest key during a scan.
// Depends on emkq_pkg for the entry type.
module emkq_scan #(
	parameter int DEPTH = emkq_pkg::DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clr,
	input  logic                upd,
	input  emkq_pkg::entry_t    cand,
	input  logic [AW-1:0]       cand_pos,
	output logic                found,
	output logic [AW-1:0]       best_pos,
	output emkq_pkg::entry_t    best
);
	import emkq_pkg::*;

	logic       found_q;
	logic [AW-1:0] best_pos_q;
	entry_t     best_q;
	logic       take;

	// Strict less-than keeps the earliest position on equal keys.
	assign take = upd && cand.elig && (!found_q || (cand.key < best_q.key));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (clr) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_q     <= cand;
			best_pos_q <= cand_pos;
		end
	end

	assign found    = found_q;
	assign best_pos = best_pos_q;
	assign best     = best_q;

endmodule

@@ hw/rtl/eligible_min_key_queue_unit.sv @@
// Top level of the eligible minimum-key queue: sequencer, entry count and result register.
// Depends on emkq_pkg, emkq_store, emkq_scan and assert_macros.svh.
//
// Channel  Dir  Fields (lowest bit first)
// s_*      in   tuser: cmd; tdata: entry_id, eligible, time_key, zero pad
// m_*      out  tuser: status; tdata: out_id, out_time_key, occupancy, zero pad
//
// An enqueue or a rejected command completes in the idle state in which it is accepted.
// A dequeue scans every held entry, then shifts each entry above the removed position down by one;
// the scan and the shift both use the single read port of the entry memory.
// A dequeue that finds no eligible entry returns to idle after the scan, with no shift or removal.
// Input is taken only when idle and the result register is free or being drained.
// Reset empties the queue; memory contents are not cleared.
module eligible_min_key_queue_unit #(
	parameter int DEPTH = emkq_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // entry_id[15:0], eligible[16], time_key[48:17], zero[55:49]
	input  logic [0:0]  s_tuser,   // cmd[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // out_id[15:0], out_time_key[47:16], occupancy[54:48], zero[55]
	output logic [2:0]  m_tuser    // status[2:0]
);
	import emkq_pkg::*;

	`include "assert_macros.svh"

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	state_t         state_q, state_d;
	logic [CW-1:0]  cnt_q, cnt_d;
	logic [AW-1:0]  ptr_q, ptr_d;
	logic           rd_pend_s1, wr_pend_s1;
	logic [AW-1:0]  addr_s1;

	logic           out_valid_q;
	status_t        status_q;
	logic [ID_W-1:0]  out_id_q;
	logic [KEY_W-1:0] out_key_q;
	logic [OCC_W-1:0] occ_q;

	logic           out_free, in_acc, full, empty;
	logic           scan_last, shift_last, need_shift;
	cmd_t           in_cmd;
	entry_t         in_entry;

	logic           rd_en, wr_en, scan_clr, res_load;
	logic [AW-1:0]  rd_addr, wr_addr;
	entry_t         wr_data, rd_data;
	status_t        res_status;

	logic           found;
	logic [AW-1:0]  best_pos;
	entry_t         best;

	assign out_free  = !out_valid_q || m_tready;
	assign s_tready  = (state_q == S_IDLE) && out_free;
	assign in_acc    = s_tvalid && s_tready;
	assign in_cmd    = cmd_t'(s_tuser[0]);
	assign in_entry  = '{id: s_tdata[15:0], elig: s_tdata[16], key: s_tdata[48:17]};

	assign full       = (cnt_q == CW'(DEPTH));
	assign empty      = (cnt_q == '0);
	assign scan_last  = (CW'(ptr_q) == (cnt_q - CW'(1)));
	assign shift_last = ((CW'(ptr_q) + CW'(2)) == cnt_q);
	assign need_shift = ((CW'(best_pos) + CW'(1)) < cnt_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc && (in_cmd == CMD_DEQ) && !empty) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_last) begin
					state_d = S_SCAN_LAST;
				end
			end
			S_SCAN_LAST: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				priority if (!found) begin
					state_d = S_IDLE;
				end else if (need_shift) begin
					state_d = S_SHIFT;
				end else begin
					state_d = S_REMOVE;
				end
			end
			S_SHIFT: begin
				if (shift_last) begin
					state_d = S_REMOVE;
				end
			end
			S_REMOVE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		rd_en      = 1'b0;
		rd_addr    = ptr_q;
		wr_en      = 1'b0;
		wr_addr    = AW'(cnt_q);
		wr_data    = in_entry;
		scan_clr   = 1'b0;
		res_load   = 1'b0;
		res_status = ST_ENQUEUED;
		cnt_d      = cnt_q;
		ptr_d      = ptr_q;
		unique case (state_q)
			S_IDLE: begin
				ptr_d = '0;
				if (in_acc) begin
					res_load = 1'b1;
					if (in_cmd == CMD_ENQ) begin
						if (full) begin
							res_status = ST_FULL;
						end else begin
							res_status = ST_ENQUEUED;
							wr_en      = 1'b1;
							cnt_d      = cnt_q + CW'(1);
						end
					end else if (empty) begin
						res_status = ST_EMPTY;
					end else begin
						res_load = 1'b0;
						scan_clr = 1'b1;
					end
				end
			end
			S_SCAN: begin
				rd_en = 1'b1;
				if (!scan_last) begin
					ptr_d = ptr_q + AW'(1);
				end
			end
			S_SCAN_LAST: begin
			end
			S_DECIDE: begin
				ptr_d = best_pos;
				if (!found) begin
					res_load   = 1'b1;
					res_status = ST_NONE_ELIGIBLE;
				end
			end
			S_SHIFT: begin
				rd_en   = 1'b1;
				rd_addr = ptr_q + AW'(1);
				ptr_d   = ptr_q + AW'(1);
			end
			S_REMOVE: begin
				res_load   = 1'b1;
				res_status = ST_DEQUEUED;
				cnt_d      = cnt_q - CW'(1);
			end
			default: begin
			end
		endcase
		// The entry read during the previous shift cycle moves down by one position.
		if (wr_pend_s1) begin
			wr_en   = 1'b1;
			wr_addr = addr_s1;
			wr_data = rd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			ptr_q       <= '0;
			rd_pend_s1  <= 1'b0;
			wr_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			cnt_q      <= cnt_d;
			ptr_q      <= ptr_d;
			rd_pend_s1 <= (state_q == S_SCAN);
			wr_pend_s1 <= (state_q == S_SHIFT);
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= ptr_q;
		if (res_load) begin
			status_q  <= res_status;
			occ_q     <= OCC_W'(cnt_d);
			out_id_q  <= (res_status == ST_DEQUEUED) ? best.id : '0;
			out_key_q <= (res_status == ST_DEQUEUED) ? best.key : '0;
		end
	end

	emkq_store #(
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	emkq_scan #(
		.DEPTH(DEPTH)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr      (scan_clr),
		.upd      (rd_pend_s1),
		.cand     (rd_data),
		.cand_pos (addr_s1),
		.found    (found),
		.best_pos (best_pos),
		.best     (best)
	);

	assign m_tvalid = out_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {1'b0, occ_q, out_key_q, out_id_q};

	`ASSERT_SAME(a_cnt_bound, 1'b1, cnt_q <= CW'(DEPTH), "entry count exceeds depth")
	`ASSERT_SAME(a_res_free, res_load, out_free, "result loaded over an untaken result")
	`ASSERT_NEXT(a_remove_dec, state_q == S_REMOVE, cnt_q == $past(cnt_q) - CW'(1), "remove did not decrement the count")
	`ASSERT_SAME(a_shift_addr, wr_pend_s1, CW'(addr_s1) < cnt_q, "shift write beyond held entries")

endmodule
